[sv/forf_pkg.sv]
`default_nettype none
package forf_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int COORD_W = 16;
  // edges are held wide enough that x + w never wraps
  localparam int EDGE_W = COORD_W + 2;
  // cell position compare width, covers depths up to 512 and counts up to 127
  localparam int POS_W = 9;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        opcode;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [COORD_W-1:0]  rect_x;
    logic signed [COORD_W-1:0]  rect_y;
    logic [COORD_W-1:0]         rect_w;
    logic [COORD_W-1:0]         rect_h;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] hit_index;
  } rsp_t;

  // query transaction walking down the row of cells
  typedef struct packed {
    logic                      valid;
    logic                      empty;
    logic signed [EDGE_W-1:0]  left;
    logic signed [EDGE_W-1:0]  top;
    logic signed [EDGE_W-1:0]  right;
    logic signed [EDGE_W-1:0]  bottom;
    logic                      found;
    logic [INDEX_W-1:0]        idx;
  } token_t;

  // store strobe from the top to every cell
  typedef struct packed {
    logic               wr;
    logic [INDEX_W-1:0] index;
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] top;
    logic signed [EDGE_W-1:0] right;
    logic signed [EDGE_W-1:0] bottom;
    logic               empty;
  } load_t;

endpackage
`default_nettype wire

[sv/forf_cell.sv]
`default_nettype none
module forf_cell
  import forf_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [COUNT_W-1:0] count,
  input  wire load_t              load,
  input  wire token_t             tok_in,
  output token_t                  tok_out
);

  localparam logic [POS_W-1:0] CELL_POS = POS_W'(CELL_IDX);

  logic signed [EDGE_W-1:0] left;
  logic signed [EDGE_W-1:0] top;
  logic signed [EDGE_W-1:0] right;
  logic signed [EDGE_W-1:0] bottom;
  logic                     empty;

  logic   wr_here;
  logic   enabled;
  logic   overlap;
  token_t tok_next;

  assign wr_here = load.wr && (POS_W'(load.index) == CELL_POS);
  assign enabled = CELL_POS < POS_W'(count);

  // half-open edges on both axes
  assign overlap = !empty && !tok_in.empty
                && (tok_in.right > left) && (right > tok_in.left)
                && (tok_in.bottom > top) && (bottom > tok_in.top);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.found && enabled && overlap) begin
      tok_next.found = 1'b1;
      tok_next.idx   = CELL_POS[INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (wr_here) begin
      empty <= load.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      left   <= load.left;
      top    <= load.top;
      right  <= load.right;
      bottom <= load.bottom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
`default_nettype wire

[sv/first_overlapping_rect_finder.sv]
// First overlapping rectangle finder.
// req channel (req_valid/req_stall/req): a load transaction writes one table
// entry and gives no response; a query transaction carries an actor rectangle
// and gives exactly one response on rsp (rsp_valid/rsp_stall/rsp): the lowest
// entry below triggers_in_use that overlaps the actor, or hit = 0.
// triggers_in_use is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, which the block does not enforce. The table lives
// in a row of TABLE_DEPTH cells, one entry per cell. A query walks the row one
// cell per cycle, through every cell register, then the fin and output
// registers, whatever triggers_in_use holds. Loads can be issued back to back
// while req_stall is low. req_stall stays high from the acceptance of a query
// until its response has moved into the output register; a stalled response
// holds in the output register while a following transaction is already
// accepted. Reset clears every entry to empty, triggers_in_use to zero and
// drops any transaction in flight.
`default_nettype none
module first_overlapping_rect_finder
  import forf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_t               req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp,
  input  wire logic               cfg_wr_en,
  input  wire logic [COUNT_W-1:0] cfg_wr_data
);

  logic [COUNT_W-1:0] triggers_in_use;
  logic               scanning;
  logic               fin_valid;
  rsp_t               fin;

  logic   accept;
  logic   rsp_free;
  load_t  load;
  token_t tok [TABLE_DEPTH+1];

  logic signed [EDGE_W-1:0] req_left;
  logic signed [EDGE_W-1:0] req_top;
  logic signed [EDGE_W-1:0] req_right;
  logic signed [EDGE_W-1:0] req_bottom;
  logic                     req_empty;

  assign req_stall = scanning || fin_valid;
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign req_left   = EDGE_W'(req.rect_x);
  assign req_top    = EDGE_W'(req.rect_y);
  assign req_right  = req_left + $signed({2'b00, req.rect_w});
  assign req_bottom = req_top + $signed({2'b00, req.rect_h});
  assign req_empty  = (req.rect_w == '0) || (req.rect_h == '0);

  always_comb begin
    load.wr     = accept && (req.opcode == OP_LOAD);
    load.index  = req.entry_index;
    load.left   = req_left;
    load.top    = req_top;
    load.right  = req_right;
    load.bottom = req_bottom;
    load.empty  = req_empty;
  end

  always_comb begin
    tok[0].valid  = accept && (req.opcode == OP_QUERY);
    tok[0].empty  = req_empty;
    tok[0].left   = req_left;
    tok[0].top    = req_top;
    tok[0].right  = req_right;
    tok[0].bottom = req_bottom;
    tok[0].found  = 1'b0;
    tok[0].idx    = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    forf_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (triggers_in_use),
      .load    (load),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      triggers_in_use <= '0;
    end else if (cfg_wr_en) begin
      triggers_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
    end else if (tok[0].valid) begin
      scanning <= 1'b1;
    end else if (tok[TABLE_DEPTH].valid) begin
      scanning <= 1'b0;
    end
  end

  // end of the row lands here, then moves on when the output slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (tok[TABLE_DEPTH].valid) begin
      fin_valid <= 1'b1;
    end else if (fin_valid && rsp_free) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[TABLE_DEPTH].valid) begin
      fin.hit       <= tok[TABLE_DEPTH].found;
      fin.hit_index <= tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].idx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_valid && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && rsp_free) begin
      rsp <= fin;
    end
  end

endmodule
`default_nettype wire
